// ----- hw/rtl/ins_pkg.sv -----
// ----------------------------------------------------------------------------
// ins_pkg: shared types and defaults for the insertion sorter
// Holds default sizes and the command/status structs between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package ins_pkg;

  // default sizes
  localparam int DEPTH_DEF     = 16;
  localparam int KEY_WIDTH_DEF = 32;

  // controller to datapath commands
  typedef struct packed {
    logic insert;  // place the arriving key into the row
    logic drain;   // send the head key out and shift the row down
  } ctrl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic last_one;  // exactly one key left in the row
  } dp_status_t;

endpackage

// ----- hw/rtl/ins_datapath.sv -----
// ----------------------------------------------------------------------------
// ins_datapath: sorted key row with parallel compare-and-shift
// Each cell compares its key with the arriving one and either keeps its
// key, takes its lower neighbor's key or takes the new key. On drain the
// row shifts toward cell zero, one key per cycle onto the result ports.
// ----------------------------------------------------------------------------
module ins_datapath #(
  parameter int DEPTH     = ins_pkg::DEPTH_DEF,
  parameter int KEY_WIDTH = ins_pkg::KEY_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ins_pkg::ctrl_cmd_t    cmd,
  output ins_pkg::dp_status_t   status,
  input  logic [KEY_WIDTH-1:0]  key_in,
  output logic                  out_valid,
  output logic [KEY_WIDTH-1:0]  out_key_out,
  output logic                  out_last_out,
  output logic                  out_keys_dropped
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [KEY_WIDTH-1:0] keys_r   [DEPTH];
  logic [KEY_WIDTH-1:0] keys_nxt [DEPTH];
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic                 ovf_r, ovf_nxt;
  logic [DEPTH-1:0]     gt;
  logic [DEPTH-1:0]     place;
  logic                 full;

  logic                 out_valid_r;
  logic [KEY_WIDTH-1:0] out_key_r;
  logic                 out_last_r;
  logic                 out_drop_r;

  assign full            = (count_r == CNT_W'(DEPTH));
  assign status.last_one = (count_r == CNT_W'(1));

  // per-cell compare: stored key greater than the arriving key
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      gt[i]    = (CNT_W'(i) < count_r) && ($signed(keys_r[i]) > $signed(key_in));
      place[i] = (CNT_W'(i) < count_r) ? gt[i] : (CNT_W'(i) == count_r);
    end
  end

  // next row contents
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      keys_nxt[i] = keys_r[i];
      if (cmd.drain) begin
        if (i < DEPTH - 1) begin
          keys_nxt[i] = keys_r[(i + 1) % DEPTH];
        end
      end else if (cmd.insert && !full && place[i]) begin
        if (i > 0 && gt[(i + DEPTH - 1) % DEPTH]) begin
          keys_nxt[i] = keys_r[(i + DEPTH - 1) % DEPTH];
        end else begin
          keys_nxt[i] = key_in;
        end
      end
    end
  end

  // fill count and sticky drop flag
  always_comb begin
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    if (cmd.drain) begin
      count_nxt = count_r - CNT_W'(1);
      if (status.last_one) begin
        ovf_nxt = 1'b0;
      end
    end else if (cmd.insert) begin
      if (full) begin
        ovf_nxt = 1'b1;
      end else begin
        count_nxt = count_r + CNT_W'(1);
      end
    end
  end

  // key row, no reset needed
  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      keys_r[i] <= keys_nxt[i];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= cmd.drain;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.drain) begin
      out_key_r  <= keys_r[0];
      out_last_r <= status.last_one;
      out_drop_r <= ovf_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_key_out      = out_key_r;
  assign out_last_out     = out_last_r;
  assign out_keys_dropped = out_drop_r;

  // checks
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("fill count above depth");

  a_drain_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.drain |-> count_r != '0)
    else $error("drain of an empty row");

  a_drain_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.drain && status.last_one |=> count_r == '0 && !ovf_r)
    else $error("row not emptied after last result");

  a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.insert && !cmd.drain && full |=> ovf_r && count_r == CNT_W'(DEPTH))
    else $error("key into full row not flagged");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.insert && cmd.drain))
    else $error("insert and drain together");

endmodule

// ----- hw/rtl/ins_controller.sv -----
// ----------------------------------------------------------------------------
// ins_controller: sequencer for the insertion sorter
// Takes keys while idle, and after the end-of-set key walks the datapath
// through one drain step per stored key.
// ----------------------------------------------------------------------------
module ins_controller (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 end_of_set,
  input  ins_pkg::dp_status_t  status,
  output ins_pkg::ctrl_cmd_t   cmd,
  output logic                 busy
);

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_DRAIN = 1'b1;

  logic state_r, state_nxt;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start && end_of_set) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (status.last_one) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // commands
  assign busy       = (state_r == ST_DRAIN);
  assign cmd.insert = start && !busy;
  assign cmd.drain  = busy;

endmodule

// ----- hw/rtl/insertion_sorter.sv -----
// ----------------------------------------------------------------------------
// insertion_sorter: streaming insertion sorter for signed keys
// Keeps up to DEPTH keys in ascending order and unloads them per set.
// ----------------------------------------------------------------------------
// Usage:
//   Input: a key transfer happens on a rising edge with start high and busy
//   low. One key can be taken every cycle while the block is idle; each key
//   is placed by a parallel compare-and-shift row.
//   Equal keys keep their arrival order. Keys arriving while the row holds
//   DEPTH keys are discarded and out_keys_dropped is set for that set.
//   A key with in_end_of_set high is inserted, then busy rises and the set
//   is unloaded one key per cycle in ascending order: the first result
//   shows once the controller is in its drain state and the result register
//   has taken the head key, n results for n stored keys, the last marked by
//   out_last_out. busy stays high until the drain of the last stored key,
//   and no key is taken while busy is high.
//   Output: out_valid is high with each result; the receiver takes every
//   result, there is no stall. After the last result the block is empty.
//   Reset (rst_n low, synchronous) empties the row and clears the flag.
// ----------------------------------------------------------------------------
module insertion_sorter #(
  parameter int DEPTH     = ins_pkg::DEPTH_DEF,
  parameter int KEY_WIDTH = ins_pkg::KEY_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [KEY_WIDTH-1:0] in_key_in,
  input  logic                 in_end_of_set,
  output logic                 out_valid,
  output logic [KEY_WIDTH-1:0] out_key_out,
  output logic                 out_last_out,
  output logic                 out_keys_dropped
);

  ins_pkg::ctrl_cmd_t  cmd;
  ins_pkg::dp_status_t status;

  // sequencer
  ins_controller u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .end_of_set (in_end_of_set),
    .status     (status),
    .cmd        (cmd),
    .busy       (busy)
  );

  // key row and result register
  ins_datapath #(
    .DEPTH     (DEPTH),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .status           (status),
    .key_in           (in_key_in),
    .out_valid        (out_valid),
    .out_key_out      (out_key_out),
    .out_last_out     (out_last_out),
    .out_keys_dropped (out_keys_dropped)
  );

endmodule

// ----- tb/sv/insertion_sorter_tb.sv -----
// ----------------------------------------------------------------------------
// insertion_sorter_tb: self-checking bench for the streaming insertion sorter
// Sends sets of signed keys through the start/busy port and predicts the
// sorted unload of each set, including the drop flag when a key meets a full row.
// Every result strobe is checked field by field against the oldest
// predicted key.
// ----------------------------------------------------------------------------
module insertion_sorter_tb;

  localparam int DEPTH      = ins_pkg::DEPTH_DEF;
  localparam int KEY_WIDTH  = ins_pkg::KEY_WIDTH_DEF;
  localparam int ITEM_COUNT = 430;
  localparam int IDLE_LIMIT = 2000;
  localparam int TAIL_WAIT  = 4 * DEPTH;

  typedef logic signed [KEY_WIDTH-1:0] key_t;

  // one predicted key of an unload
  typedef struct {
    key_t key;
    logic last;
    logic dropped;
  } sorted_key_t;

  // predicted row contents and the unload keys still owed by the block
  class set_sorter_model;
    key_t        held_keys[$];
    logic        dropped_any;
    sorted_key_t owed_keys[$];
    int          errors;

    function new();
      dropped_any = 1'b0;
      errors      = 0;
    endfunction

    task report(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      errors++;
    endtask

    // a key transfer: insert after every key not greater, unload on end of set
    function void take_key(input key_t key, input logic end_of_set);
      int pos;
      if (held_keys.size() >= DEPTH) begin
        dropped_any = 1'b1;
      end else begin
        pos = held_keys.size();
        while (pos > 0 && held_keys[pos-1] > key) pos--;
        held_keys.insert(pos, key);
      end
      if (end_of_set) begin
        foreach (held_keys[i]) begin
          owed_keys.push_back('{key: held_keys[i],
                                last: (i == held_keys.size() - 1),
                                dropped: dropped_any});
        end
        held_keys.delete();
        dropped_any = 1'b0;
      end
    endfunction

    // a result strobe against the oldest owed key
    task check_key(input key_t key, input logic last, input logic dropped);
      sorted_key_t exp;
      if (owed_keys.size() == 0) begin
        report($sformatf("unexpected result key %0d", key));
      end else begin
        exp = owed_keys.pop_front();
        if (key !== exp.key)
          report($sformatf("key %0d, expected %0d", key, exp.key));
        if (last !== exp.last)
          report($sformatf("last %b, expected %b (key %0d)", last, exp.last, exp.key));
        if (dropped !== exp.dropped)
          report($sformatf("dropped %b, expected %b (key %0d)", dropped, exp.dropped,
                           exp.key));
      end
    endtask

    function bit all_done();
      return owed_keys.size() == 0;
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic [KEY_WIDTH-1:0] in_key_in;
  logic                 in_end_of_set;
  logic                 out_valid;
  logic [KEY_WIDTH-1:0] out_key_out;
  logic                 out_last_out;
  logic                 out_keys_dropped;

  set_sorter_model sorter = new();
  int burst_left = 8;
  int keys_sent  = 0;
  int idle_count = 0;

  insertion_sorter #(
    .DEPTH(DEPTH),
    .KEY_WIDTH(KEY_WIDTH)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_key_in(in_key_in),
    .in_end_of_set(in_end_of_set),
    .out_valid(out_valid),
    .out_key_out(out_key_out),
    .out_last_out(out_last_out),
    .out_keys_dropped(out_keys_dropped)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // monitor: results first, so a key taken on the last unload edge follows them
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) sorter.check_key(key_t'(out_key_out), out_last_out, out_keys_dropped);
      if (start && !busy) sorter.take_key(key_t'(in_key_in), in_end_of_set);
    end
  end

  // watchdog on cycles with no transfer in either direction
  always @(posedge clk) begin
    if (!rst_n || out_valid || (start && !busy)) begin
      idle_count <= 0;
    end else if (idle_count >= IDLE_LIMIT) begin
      $display("timeout after %0d idle cycles", idle_count);
      $display("simulation failed");
      $finish;
    end else begin
      idle_count <= idle_count + 1;
    end
  end

  // one key transfer, then a random gap when the current burst runs out
  task automatic send_key(input key_t key, input logic end_of_set);
    start         <= 1'b1;
    in_key_in     <= key;
    in_end_of_set <= end_of_set;
    @(posedge clk);
    while (busy) @(posedge clk);
    keys_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      start <= 1'b0;
      repeat ($urandom_range(12, 1)) @(posedge clk);
      burst_left = ($urandom_range(5) == 0) ? $urandom_range(80, 30) : $urandom_range(20, 1);
    end
  endtask

  // keys mixed from full range, a narrow band for ties, and the extremes
  function automatic key_t random_key();
    case ($urandom_range(3))
      0: return key_t'(int'($urandom_range(8)) - 4);
      1: return $urandom_range(1) ? {1'b0, {(KEY_WIDTH-1){1'b1}}}
                                  : {1'b1, {(KEY_WIDTH-1){1'b0}}};
      default: return key_t'($urandom);
    endcase
  endfunction

  // mostly short sets, some that fill the row and some that overflow it
  function automatic int random_set_size();
    int pick;
    pick = $urandom_range(99);
    if (pick < 65) return $urandom_range(6, 1);
    if (pick < 82) return $urandom_range(DEPTH - 1, 7);
    if (pick < 92) return DEPTH;
    return $urandom_range(DEPTH + 4, DEPTH + 1);
  endfunction

  task automatic send_set(input int size);
    for (int i = 0; i < size; i++) send_key(random_key(), i == size - 1);
  endtask

  // stimulus
  initial begin
    key_t edge_keys[7];
    edge_keys = '{{1'b0, {(KEY_WIDTH-1){1'b1}}}, {1'b1, {(KEY_WIDTH-1){1'b0}}}, '0, '1,
                  key_t'(1), key_t'(5), key_t'(5)};
    rst_n         <= 1'b0;
    start         <= 1'b0;
    in_key_in     <= '0;
    in_end_of_set <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // single-key set holding the most negative key
    send_key({1'b1, {(KEY_WIDTH-1){1'b0}}}, 1'b1);
    // both extremes, zero, minus one and a tie
    foreach (edge_keys[i]) send_key(edge_keys[i], i == 6);
    // full row in descending order, end-of-set key dropped on a full row
    for (int i = 0; i < DEPTH; i++) send_key(key_t'(DEPTH - i), 1'b0);
    send_key(key_t'(-7), 1'b1);

    // random sets
    while (keys_sent < ITEM_COUNT) send_set(random_set_size());

    // drain
    start <= 1'b0;
    @(posedge clk);
    while (!sorter.all_done()) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);
    if (sorter.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
